### hw/rtl/double_ended_queue_defines.svh
// Assertion macros for the double-ended queue RTL.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check that is off while reset is asserted.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies.
package deq_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned DataWidth       = 32;
  localparam int unsigned OccWidth        = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic push_front;  // shift toward the back, cell 0 takes the new value
    logic push_back;   // cell at the current count takes the new value
    logic pop_front;   // shift toward the front
  } cell_ctl_t;

endpackage

### hw/rtl/deq_cell.sv
// One storage cell of the queue row; shifts with its neighbors.
// Depends on deq_pkg.
module deq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                                   clk,
  input  deq_pkg::cell_ctl_t                     ctl,
  input  logic [CW-1:0]                          count,
  input  logic signed [deq_pkg::DataWidth-1:0]   value,
  input  logic signed [deq_pkg::DataWidth-1:0]   left_data,
  input  logic signed [deq_pkg::DataWidth-1:0]   right_data,
  output logic signed [deq_pkg::DataWidth-1:0]   data,
  output logic signed [deq_pkg::DataWidth-1:0]   tail_data
);

  logic at_count;
  logic is_tail;

  assign at_count  = (count == CW'(IDX));
  assign is_tail   = (count == CW'(IDX + 1));
  assign tail_data = is_tail ? data : '0;

  always_ff @(posedge clk) begin
    priority if (ctl.push_front) begin
      data <= left_data;
    end else if (ctl.push_back && at_count) begin
      data <= value;
    end else if (ctl.pop_front) begin
      data <= right_data;
    end else begin
      data <= data;
    end
  end

endmodule

### hw/rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values: one operation per cycle
// (push front/back, pop front/back, peek front). busy never rises, so an
// operation can be issued in every cycle; its result appears on the cycle
// after the transfer, for one cycle, marked by done, and cannot be stalled.
// Storage is a row of CAPACITY cells with the front entry always in cell 0:
// a push or pop at the front shifts the whole row by one cell in that cycle.
// Depends on deq_pkg, deq_cell and double_ended_queue_defines.svh.
module double_ended_queue #(
  parameter int unsigned CAPACITY = deq_pkg::CapacityDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           opcode,
  input  logic signed [deq_pkg::DataWidth-1:0] value,
  output logic                                 done,
  output logic signed [deq_pkg::DataWidth-1:0] result_value,
  output logic [1:0]                           status,
  output logic [deq_pkg::OccWidth-1:0]         occupancy
);

  `include "double_ended_queue_defines.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                                 accept;
  logic [CW-1:0]                        count;
  logic [CW-1:0]                        count_next;
  logic                                 full;
  logic                                 empty;
  logic                                 full_push;
  logic                                 empty_read;
  deq_pkg::cell_ctl_t                   ctl;
  deq_pkg::status_t                     st;
  logic signed [deq_pkg::DataWidth-1:0] res;
  logic signed [deq_pkg::DataWidth-1:0] back_data;
  logic signed [deq_pkg::DataWidth-1:0] cell_data [CAPACITY];
  logic signed [deq_pkg::DataWidth-1:0] cell_tail [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);

  assign full_push  = accept && full &&
                      (opcode == deq_pkg::OP_PUSH_FRONT || opcode == deq_pkg::OP_PUSH_BACK);
  assign empty_read = accept && empty &&
                      (opcode == deq_pkg::OP_POP_FRONT || opcode == deq_pkg::OP_POP_BACK ||
                       opcode == deq_pkg::OP_PEEK_FRONT);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [deq_pkg::DataWidth-1:0] left_in;
      logic signed [deq_pkg::DataWidth-1:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = value;
      end else begin : g_mid_l
        assign left_in = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_in = cell_data[gi];
      end else begin : g_mid_r
        assign right_in = cell_data[gi+1];
      end
      deq_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .value      (value),
        .left_data  (left_in),
        .right_data (right_in),
        .data       (cell_data[gi]),
        .tail_data  (cell_tail[gi])
      );
    end
  endgenerate

  // Exactly one cell flags itself as the tail when the queue is not empty.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_data = back_data | cell_tail[i];
    end
  end

  always_comb begin
    ctl        = '0;
    st         = deq_pkg::ST_OK;
    res        = '0;
    count_next = count;
    if (accept) begin
      unique case (deq_pkg::op_t'(opcode))
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            st = deq_pkg::ST_FULL;
          end else begin
            ctl.push_front = 1'b1;
            count_next     = count + CW'(1);
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            st = deq_pkg::ST_FULL;
          end else begin
            ctl.push_back = 1'b1;
            count_next    = count + CW'(1);
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            st = deq_pkg::ST_EMPTY;
          end else begin
            res           = cell_data[0];
            ctl.pop_front = 1'b1;
            count_next    = count - CW'(1);
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            st = deq_pkg::ST_EMPTY;
          end else begin
            res        = back_data;
            count_next = count - CW'(1);
          end
        end
        deq_pkg::OP_PEEK_FRONT: begin
          if (empty) begin
            st = deq_pkg::ST_EMPTY;
          end else begin
            res = cell_data[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_value <= res;
      status       <= st;
      occupancy    <= deq_pkg::OccWidth'(count_next);
    end
  end

  `DEQ_ASSERT_ALWAYS(a_never_busy, busy == 1'b0, "busy raised")
  `DEQ_ASSERT(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `DEQ_ASSERT(a_done_follows, accept |=> done, "transfer without result")
  `DEQ_ASSERT(a_no_spurious, !accept |=> !done, "result without transfer")
  `DEQ_ASSERT(a_full_refuse, full_push |=> (status == deq_pkg::ST_FULL && $stable(count)),
              "push into full queue not refused")
  `DEQ_ASSERT(a_empty_flag, empty_read |=> (status == deq_pkg::ST_EMPTY && result_value == '0),
              "empty read not flagged")

endmodule
